// ----- sv/prewitt_edge_magnitude_defines.svh -----
// Assertion helpers for the edge magnitude block.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PREWITT_EDGE_MAGNITUDE_DEFINES_SVH
`define PREWITT_EDGE_MAGNITUDE_DEFINES_SVH

// Same-cycle implication.
`define PEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PEM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pem_pkg.sv -----
`default_nettype none

package pem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CFG_W  = 11;
    localparam int PIX_W  = 8;

    // Q8 gray weights: 0.07, 0.72, 0.21
    localparam int GRAY_W_BLUE  = 18;
    localparam int GRAY_W_GREEN = 184;
    localparam int GRAY_W_RED   = 54;
    localparam int GRAY_ROUND   = 128;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // Square root of a 2*PIX_W+2 bit radicand, two bits per step
    localparam int RAD_W      = 2 * PIX_W + 2;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int ITER_W     = $clog2(ROOT_STEPS);
    localparam int REM_W      = ROOT_W + 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GRAD,
        ST_MAG,
        ST_PUSH
    } pem_state_t;

    typedef enum logic [2:0] {
        MAG_IDLE,
        MAG_SQX,
        MAG_SQY,
        MAG_ROOT,
        MAG_ROUND,
        MAG_DONE
    } pem_mag_phase_t;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] gx;
        logic [PIX_W-1:0] gy;
    } pem_mag_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] mag;
    } pem_mag_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pem_mag.sv -----
`default_nettype none

module pem_mag (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire pem_pkg::pem_mag_req_t req,
    output pem_pkg::pem_mag_rsp_t rsp
);
    import pem_pkg::*;

    pem_mag_phase_t phase_reg, phase_next;

    logic [PIX_W-1:0]  gx_reg, gx_next;
    logic [PIX_W-1:0]  gy_reg, gy_next;
    logic [RAD_W-1:0]  acc_reg, acc_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [PIX_W-1:0]  mag_reg, mag_next;

    // shared squarer
    logic [PIX_W-1:0]   sq_op;
    logic [2*PIX_W-1:0] sq;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W:0]   rounded;
    logic              round_up;

    assign sq_op = (phase_reg == MAG_SQX) ? gx_reg : gy_reg;
    assign sq    = sq_op * sq_op;

    assign rem_shift = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign round_up  = rem_reg > REM_W'(root_reg);
    assign rounded   = (ROOT_W+1)'(root_reg) + (ROOT_W+1)'(round_up);

    always_comb begin
        phase_next = phase_reg;
        gx_next    = gx_reg;
        gy_next    = gy_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        iter_next  = iter_reg;
        mag_next   = mag_reg;
        case (phase_reg)
            MAG_IDLE: begin
                if (req.start) begin
                    gx_next    = req.gx;
                    gy_next    = req.gy;
                    phase_next = MAG_SQX;
                end
            end
            MAG_SQX: begin
                acc_next   = RAD_W'(sq);
                phase_next = MAG_SQY;
            end
            MAG_SQY: begin
                acc_next   = acc_reg + RAD_W'(sq);
                root_next  = '0;
                rem_next   = '0;
                iter_next  = '0;
                phase_next = MAG_ROOT;
            end
            MAG_ROOT: begin
                acc_next = acc_reg << 2;
                if (rem_shift >= trial) begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ROOT_STEPS - 1)) begin
                    phase_next = MAG_ROUND;
                end
            end
            MAG_ROUND: begin
                // round to nearest, then saturate
                if (rounded[ROOT_W:PIX_W] != '0) begin
                    mag_next = '1;
                end else begin
                    mag_next = rounded[PIX_W-1:0];
                end
                phase_next = MAG_DONE;
            end
            MAG_DONE: begin
                phase_next = MAG_IDLE;
            end
            default: begin
                phase_next = MAG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MAG_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        gx_reg   <= gx_next;
        gy_reg   <= gy_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        iter_reg <= iter_next;
        mag_reg  <= mag_next;
    end

    assign rsp.done = (phase_reg == MAG_DONE);
    assign rsp.mag  = mag_reg;

endmodule

`default_nettype wire

// ----- sv/prewitt_edge_magnitude.sv -----
// Prewitt edge magnitude over a raster stream of BGR pixels.
// Input channel (s_*): one pixel per transaction, raster order, row after row.
// Output channel (m_*): gradient magnitudes, 0..255. Pixels 0 and 1 of a row give
//   nothing, each later pixel gives one result, and the last pixel of a row gives
//   three; m_last_of_run marks the final result of a pixel, m_end_of_frame the
//   last result of the frame's last row.
// Config channel (cfg_*): index 0 sets line_width, index 1 frame_height; always
//   ready, write only while no pixel is in flight.
// Sequence: a pixel is accepted, then updates the line store; each result then runs the
//   gradient, two squarings and 9 two-bit root steps in the shared magnitude unit,
//   rounding, and the load of the output register. The root steps of the magnitude
//   unit take the largest part of each result.
// Line store reads are registered; read at accept, write in the next cycle.
// s_ready is high only while no pixel is in work. A finished result waits in the
//   output register; the next pixel is taken meanwhile, and a stalled receiver
//   holds the sequencer only when a further result is ready to load.
// Reset clears the counters, the window and the config (640 x 480); the line
//   stores are not cleared, as rows behind the first row of a frame read as zero.
`default_nettype none

`include "prewitt_edge_magnitude_defines.svh"

module prewitt_edge_magnitude (
    input  wire                               aclk,
    input  wire                               aresetn,

    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [pem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [pem_pkg::CFG_W-1:0]         cfg_data,

    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  [pem_pkg::PIX_W-1:0]         s_blue,
    input  wire  [pem_pkg::PIX_W-1:0]         s_green,
    input  wire  [pem_pkg::PIX_W-1:0]         s_red,

    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [pem_pkg::PIX_W-1:0]         m_edge_magnitude,
    output logic                              m_last_of_run,
    output logic                              m_end_of_frame
);
    import pem_pkg::*;

    pem_state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_width_reg, cfg_width_next;
    logic [CFG_W-1:0]  cfg_height_reg, cfg_height_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [1:0]        emit_left_reg, emit_left_next;
    logic [PIX_W-1:0]  win_reg [3][3];
    logic [PIX_W-1:0]  win_next [3][3];
    logic              m_valid_reg, m_valid_next;

    logic [PIX_W-1:0]  blue_reg, blue_next;
    logic [PIX_W-1:0]  green_reg, green_next;
    logic [PIX_W-1:0]  red_reg, red_next;
    logic [ADDR_W-1:0] col_cur_reg, col_cur_next;
    logic [ROW_W-1:0]  row_cur_reg, row_cur_next;
    logic              row_end_reg, row_end_next;
    logic              eof_reg, eof_next;
    logic [PIX_W-1:0]  m_mag_reg, m_mag_next;
    logic              m_last_reg, m_last_next;
    logic              m_eof_reg, m_eof_next;

    // line stores
    logic [PIX_W-1:0]  line_prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0]  line_prev2_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  rd_prev_reg;
    logic [PIX_W-1:0]  rd_prev2_reg;

    logic [CFG_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [CFG_W-1:0]  w_m1;
    logic [CFG_W-1:0]  h_m1;
    logic [ADDR_W-1:0] col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic              s_accept;
    logic              mem_we;
    logic [15:0]       gray_sum;
    logic [PIX_W-1:0]  gray;
    logic [PIX_W-1:0]  tap_prev;
    logic [PIX_W-1:0]  tap_prev2;
    logic [PIX_W+1:0]  sum_left, sum_right, sum_top, sum_bottom;
    logic              out_load;

    pem_mag_req_t mag_req;
    pem_mag_rsp_t mag_rsp;

    function automatic logic [PIX_W-1:0] clamp_diff(input logic [PIX_W+1:0] a,
                                                    input logic [PIX_W+1:0] b);
        logic [PIX_W+2:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[PIX_W+2]) begin
            return '0;
        end else if (d[PIX_W+1:PIX_W] != 2'b00) begin
            return '1;
        end
        return d[PIX_W-1:0];
    endfunction

    // Clamp the config to its legal range, then pull the counters inside it
    assign w_eff = (cfg_width_reg < CFG_W'(3)) ? CFG_W'(3) :
                   (cfg_width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_width_reg;
    assign h_eff = (cfg_height_reg == '0) ? CFG_W'(1) :
                   (cfg_height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_height_reg;
    assign w_m1  = w_eff - 1'b1;
    assign h_m1  = h_eff - 1'b1;

    assign col_eff = (CFG_W'(col_reg) >= w_eff) ? w_m1[ADDR_W-1:0] : col_reg;
    assign row_eff = (CFG_W'(row_reg) >= h_eff) ? h_m1[ROW_W-1:0] : row_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign mem_we    = (state_reg == ST_FETCH);

    // Gray conversion, rounded Q8
    assign gray_sum = 16'(GRAY_W_BLUE * blue_reg) + 16'(GRAY_W_GREEN * green_reg)
                    + 16'(GRAY_W_RED * red_reg) + 16'(GRAY_ROUND);
    assign gray     = gray_sum[15:8];

    // Rows behind the first row of the frame read as zero
    assign tap_prev  = (row_cur_reg != '0) ? rd_prev_reg : '0;
    assign tap_prev2 = (row_cur_reg > ROW_W'(1)) ? rd_prev2_reg : '0;

    // Window sums: left/right columns, current/two-back rows
    assign sum_left   = (PIX_W+2)'(win_reg[0][0]) + (PIX_W+2)'(win_reg[1][0])
                      + (PIX_W+2)'(win_reg[2][0]);
    assign sum_right  = (PIX_W+2)'(win_reg[0][2]) + (PIX_W+2)'(win_reg[1][2])
                      + (PIX_W+2)'(win_reg[2][2]);
    assign sum_top    = (PIX_W+2)'(win_reg[0][0]) + (PIX_W+2)'(win_reg[0][1])
                      + (PIX_W+2)'(win_reg[0][2]);
    assign sum_bottom = (PIX_W+2)'(win_reg[2][0]) + (PIX_W+2)'(win_reg[2][1])
                      + (PIX_W+2)'(win_reg[2][2]);

    assign out_load = (state_reg == ST_PUSH) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        emit_left_next  = emit_left_reg;
        win_next        = win_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        red_next        = red_reg;
        col_cur_next    = col_cur_reg;
        row_cur_next    = row_cur_reg;
        row_end_next    = row_end_reg;
        eof_next        = eof_reg;
        m_mag_next      = m_mag_reg;
        m_last_next     = m_last_reg;
        m_eof_next      = m_eof_reg;
        // drop the held result once the receiver takes it
        m_valid_next    = m_valid_reg && !m_ready;

        mag_req.start = 1'b0;
        mag_req.gx    = clamp_diff(sum_left, sum_right);
        mag_req.gy    = clamp_diff(sum_top, sum_bottom);

        if (cfg_valid) begin
            case (cfg_index)
                REG_LINE_WIDTH:   cfg_width_next  = cfg_data;
                REG_FRAME_HEIGHT: cfg_height_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    blue_next    = s_blue;
                    green_next   = s_green;
                    red_next     = s_red;
                    col_cur_next = col_eff;
                    row_cur_next = row_eff;
                    row_end_next = (col_eff == w_m1[ADDR_W-1:0]);
                    eof_next     = (row_eff == h_m1[ROW_W-1:0]);
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                // advance the window by the new column
                for (int r = 0; r < 3; r++) begin
                    win_next[r][0] = win_reg[r][1];
                    win_next[r][1] = win_reg[r][2];
                end
                win_next[0][2] = gray;
                win_next[1][2] = tap_prev;
                win_next[2][2] = tap_prev2;

                if (row_end_reg) begin
                    col_next       = '0;
                    row_next       = eof_reg ? '0 : row_cur_reg + 1'b1;
                    emit_left_next = 2'd3;
                    state_next     = ST_GRAD;
                end else begin
                    col_next = col_cur_reg + 1'b1;
                    row_next = row_cur_reg;
                    if (col_cur_reg >= ADDR_W'(2)) begin
                        emit_left_next = 2'd1;
                        state_next     = ST_GRAD;
                    end else begin
                        emit_left_next = 2'd0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_GRAD: begin
                mag_req.start = 1'b1;
                state_next    = ST_MAG;
            end
            ST_MAG: begin
                if (mag_rsp.done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    m_mag_next     = mag_rsp.mag;
                    m_last_next    = (emit_left_reg == 2'd1);
                    m_eof_next     = (emit_left_reg == 2'd1) && row_end_reg && eof_reg;
                    emit_left_next = emit_left_reg - 1'b1;
                    if (emit_left_reg == 2'd1) begin
                        if (row_end_reg) begin
                            for (int r = 0; r < 3; r++) begin
                                for (int c = 0; c < 3; c++) begin
                                    win_next[r][c] = '0;
                                end
                            end
                        end
                        state_next = ST_IDLE;
                    end else begin
                        // past the row end: shift in zero columns
                        for (int r = 0; r < 3; r++) begin
                            win_next[r][0] = win_reg[r][1];
                            win_next[r][1] = win_reg[r][2];
                            win_next[r][2] = '0;
                        end
                        state_next = ST_GRAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= LINE_WIDTH_RST;
            cfg_height_reg <= FRAME_HEIGHT_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            emit_left_reg  <= '0;
            m_valid_reg    <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            cfg_width_reg  <= cfg_width_next;
            cfg_height_reg <= cfg_height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            emit_left_reg  <= emit_left_next;
            m_valid_reg    <= m_valid_next;
            win_reg        <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        blue_reg    <= blue_next;
        green_reg   <= green_next;
        red_reg     <= red_next;
        col_cur_reg <= col_cur_next;
        row_cur_reg <= row_cur_next;
        row_end_reg <= row_end_next;
        eof_reg     <= eof_next;
        m_mag_reg   <= m_mag_next;
        m_last_reg  <= m_last_next;
        m_eof_reg   <= m_eof_next;
    end

    // Line stores: read at accept, write back in the next cycle at the same column
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_prev_mem[col_cur_reg]  <= gray;
            line_prev2_mem[col_cur_reg] <= rd_prev_reg;
        end
        if (s_accept) begin
            rd_prev_reg  <= line_prev_mem[col_eff];
            rd_prev2_reg <= line_prev2_mem[col_eff];
        end
    end

    pem_mag u_mag (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mag_req),
        .rsp     (mag_rsp)
    );

    assign m_valid          = m_valid_reg;
    assign m_edge_magnitude = m_mag_reg;
    assign m_last_of_run    = m_last_reg;
    assign m_end_of_frame   = m_eof_reg;

    `PEM_ASSERT_NXT(a_busy_after_accept, s_accept, !s_ready, "ready held after accept")
    `PEM_ASSERT_IMP(a_idle_no_pending, s_ready, (emit_left_reg == 2'd0) && !mag_rsp.done, "ready with results pending")
    `PEM_ASSERT_IMP(a_col_in_range, state_reg == ST_FETCH, CFG_W'(col_cur_reg) < w_eff, "column beyond line width")
    `PEM_ASSERT_IMP(a_eof_is_last, m_valid && m_end_of_frame, m_last_of_run, "frame end not on last result")

endmodule

`default_nettype wire
